FILE: design/cartridge_bank_mapper_with_irq_timer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cartridge bank mapper
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_TIMER_UNIT_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_TIMER_UNIT_MACROS_SVH

// same-cycle implication
`define CBM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Types, register decode constants and bank reset values of the mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_CPU   = 2'd2,
		REQ_PPU   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_PRG  = 2'd1,
		TGT_WRAM = 2'd2,
		TGT_CHR  = 2'd3
	} target_t;

	// register decode
	localparam logic [15:0] MAP_MASK    = 16'hF007;
	localparam logic [15:0] REG_PRG0    = 16'h8000;
	localparam logic [15:0] REG_PRG1    = 16'hA000;
	localparam logic [15:0] REG_PRG2    = 16'hC000;
	localparam logic [15:0] REG_MIRROR  = 16'h9001;
	localparam logic [15:0] REG_IRQ_EN  = 16'h9003;
	localparam logic [15:0] REG_RELOAD  = 16'h9004;
	localparam logic [15:0] REG_LATCH_H = 16'h9005;
	localparam logic [15:0] REG_LATCH_L = 16'h9006;
	localparam logic [15:0] REG_CHR_LO  = 16'hB000;
	localparam logic [15:0] REG_CHR_HI  = 16'hB007;

	// CPU windows
	localparam logic [15:0] CPU_PRG_BASE  = 16'h8000;
	localparam logic [15:0] CPU_WRAM_BASE = 16'h6000;
	localparam logic [7:0]  FIXED_BANK    = 8'hFF;

	// bank table: program banks 0..2, character banks 3..10
	localparam int          NUM_BANKS  = 11;
	localparam int          BANK_IDX_W = 4;
	localparam logic [3:0]  CHR_BASE   = 4'd3;

	typedef struct packed {
		logic                  en;
		logic [BANK_IDX_W-1:0] idx;
		logic [7:0]            data;
	} bank_wr_t;

	typedef struct packed {
		logic        irq_line;
		target_t     target;
		logic [20:0] mapped_address;
		logic        mirror_mode;
	} rsp_item_t;

	function automatic logic [7:0] bank_reset_val(input logic [BANK_IDX_W-1:0] idx);
		logic [7:0] val;
		case (idx)
			4'd0:    val = 8'h00;
			4'd1:    val = 8'h01;
			4'd2:    val = 8'hFE;
			default: val = {4'b0000, idx - CHR_BASE};
		endcase
		return val;
	endfunction

endpackage

FILE: design/cbm_in_if.sv
// ----------------------------------------------------------------------------
// cbm_in_if
// Request channel: valid/ready handshake with request type, address, data.
// ----------------------------------------------------------------------------
interface cbm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] address;
	logic [7:0]  write_data;

	modport source (output valid, req_type, address, write_data, input ready);
	modport sink   (input valid, req_type, address, write_data, output ready);
endinterface

FILE: design/cbm_out_if.sv
// ----------------------------------------------------------------------------
// cbm_out_if
// Response channel: valid/ready handshake with one mapping result.
// ----------------------------------------------------------------------------
interface cbm_out_if;
	logic        valid;
	logic        ready;
	logic        irq_line;
	logic [1:0]  target;
	logic [20:0] mapped_address;
	logic        mirror_mode;

	modport source (output valid, irq_line, target, mapped_address, mirror_mode,
		input ready);
	modport sink   (input valid, irq_line, target, mapped_address, mirror_mode,
		output ready);
endinterface

FILE: design/cbm_bank_ram.sv
// ----------------------------------------------------------------------------
// cbm_bank_ram
// Bank number table with registered read and per-entry valid bits; an entry
// not yet written reads as its power-on bank.
// ----------------------------------------------------------------------------
module cbm_bank_ram
	import cbm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  bank_wr_t              wr,
	input  logic                  rd_en,
	input  logic [BANK_IDX_W-1:0] rd_idx,
	output logic [7:0]            rd_bank
);

	logic [7:0]            mem [NUM_BANKS];
	logic [NUM_BANKS-1:0]  vld_q;
	logic [7:0]            dat_q;
	logic                  hit_q;
	logic [BANK_IDX_W-1:0] idx_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
	end

	// mark written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.idx] <= 1'b1;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			dat_q <= mem[rd_idx];
			hit_q <= vld_q[rd_idx];
			idx_q <= rd_idx;
		end
	end

	assign rd_bank = hit_q ? dat_q : bank_reset_val(idx_q);

endmodule

FILE: design/cbm_regs.sv
// ----------------------------------------------------------------------------
// cbm_regs
// Register write decode, mirroring bit and the CPU-cycle IRQ timer.
// ----------------------------------------------------------------------------
module cbm_regs
	import cbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  req_kind_t   kind,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output bank_wr_t    bank_wr,
	output logic        irq_next,
	output logic        mirror_next
);

	logic        en_q, irq_q, mirror_q;
	logic [15:0] cnt_q, latch_q;
	logic        en_d, irq_d, mirror_d;
	logic [15:0] cnt_d, latch_d, cnt_dec, masked;

	assign masked  = address & MAP_MASK;
	assign cnt_dec = cnt_q - 16'd1;

	// decode the request and work out the next register values
	always_comb begin
		en_d        = en_q;
		irq_d       = irq_q;
		mirror_d    = mirror_q;
		cnt_d       = cnt_q;
		latch_d     = latch_q;
		bank_wr.en  = 1'b0;
		bank_wr.idx = '0;
		bank_wr.data = write_data;
		if (kind == REQ_WRITE && address[15]) begin
			unique case (masked) inside
				REG_PRG0: begin
					bank_wr.en  = accept;
					bank_wr.idx = 4'd0;
				end
				REG_PRG1: begin
					bank_wr.en  = accept;
					bank_wr.idx = 4'd1;
				end
				REG_PRG2: begin
					bank_wr.en  = accept;
					bank_wr.idx = 4'd2;
				end
				REG_MIRROR: mirror_d = ~write_data[7];
				REG_IRQ_EN: begin
					en_d  = write_data[7];
					irq_d = 1'b0;
				end
				REG_RELOAD: begin
					cnt_d = latch_q;
					irq_d = 1'b0;
				end
				REG_LATCH_H: latch_d = {write_data, latch_q[7:0]};
				REG_LATCH_L: latch_d = {latch_q[15:8], write_data};
				[REG_CHR_LO:REG_CHR_HI]: begin
					bank_wr.en  = accept;
					bank_wr.idx = CHR_BASE + {1'b0, address[2:0]};
				end
				default: ;
			endcase
		end else if (kind == REQ_TICK && en_q) begin
			cnt_d = cnt_dec;
			if (cnt_dec == 16'd0) begin
				en_d  = 1'b0;
				irq_d = 1'b1;
			end
		end
	end

	// commit on accepted requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= 1'b0;
			irq_q    <= 1'b0;
			mirror_q <= 1'b0;
			cnt_q    <= '0;
			latch_q  <= '0;
		end else if (accept) begin
			en_q     <= en_d;
			irq_q    <= irq_d;
			mirror_q <= mirror_d;
			cnt_q    <= cnt_d;
			latch_q  <= latch_d;
		end
	end

	assign irq_next    = irq_d;
	assign mirror_next = mirror_d;

endmodule

FILE: design/cbm_out_fifo.sv
// ----------------------------------------------------------------------------
// cbm_out_fifo
// Two-entry response buffer: head register plus skid slot.
// ----------------------------------------------------------------------------
`include "cartridge_bank_mapper_with_irq_timer_unit_macros.svh"

module cbm_out_fifo
	import cbm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rsp_item_t push_item,
	output logic      full,
	output logic      head_valid,
	output rsp_item_t head_item,
	input  logic      pop_ready
);

	logic      head_v_q, sk_v_q;
	rsp_item_t head_q, sk_q;
	logic      pop;

	assign pop = head_v_q && pop_ready;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			sk_v_q   <= 1'b0;
		end else begin
			if (push && !pop) begin
				if (head_v_q) begin
					sk_v_q <= 1'b1;
				end
				head_v_q <= 1'b1;
			end else if (pop && !push) begin
				if (sk_v_q) begin
					sk_v_q <= 1'b0;
				end else begin
					head_v_q <= 1'b0;
				end
			end
		end
	end

	// payload slots
	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (head_v_q) begin
				sk_q <= push_item;
			end else begin
				head_q <= push_item;
			end
		end else if (pop && !push) begin
			if (sk_v_q) begin
				head_q <= sk_q;
			end
		end else if (pop && push) begin
			if (sk_v_q) begin
				head_q <= sk_q;
				sk_q   <= push_item;
			end else begin
				head_q <= push_item;
			end
		end
	end

	assign full       = sk_v_q;
	assign head_valid = head_v_q;
	assign head_item  = head_q;

	`CBM_ASSERT_IMPL(a_skid_needs_head, clk, arst_n, sk_v_q, head_v_q, "skid without head")
	`CBM_ASSERT_IMPL(a_no_overflow, clk, arst_n, push && sk_v_q, pop, "push into full buffer")
	`CBM_ASSERT_NEXT(a_skid_holds, clk, arst_n, sk_v_q && !pop, sk_v_q && $stable(sk_q),
		"skid entry lost")

endmodule

FILE: design/cartridge_bank_mapper_with_irq_timer_unit.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq_timer_unit
// Cartridge bank switching with CPU-cycle IRQ timer.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per handshake: register write, CPU cycle tick,
//   CPU address translate or PPU address translate. rsp returns exactly one
//   result per request, in order: IRQ line and mirroring after the request,
//   plus target and mapped address for translates (zero otherwise).
//   From acceptance to rsp.valid a request passes the registered read of the
//   bank table, then the response register; it may wait between the two.
//   Throughput is one request per clock while rsp keeps up; the bank table
//   has one write and one read port, and each request uses each at most
//   once at acceptance, so back-to-back requests never collide on an entry.
//   Reset clears the timer, IRQ, mirroring and the bank valid bits; the bank
//   table then reads its power-on banks with no clearing pass.
//   When rsp stalls, results collect in a two-entry buffer; req.ready drops
//   only once both entries are full, and a request already in the read stage
//   waits there until space frees.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_irq_timer_unit
	import cbm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	cbm_in_if.sink     req,
	cbm_out_if.source  rsp
);

	logic                  accept;
	req_kind_t             kind;
	bank_wr_t              bank_wr;
	logic                  irq_next, mirror_next;
	logic [BANK_IDX_W-1:0] rd_idx;
	logic [7:0]            rd_bank;

	logic                  v_s1, irq_s1, mirror_s1;
	req_kind_t             kind_s1;
	logic [15:0]           addr_s1;
	logic                  s1_move, fifo_full;
	rsp_item_t             item_s1, head_item;
	logic                  head_valid;

	assign kind    = req_kind_t'(req.req_type);
	assign s1_move = v_s1 && !fifo_full;
	assign req.ready = !v_s1 || s1_move;
	assign accept  = req.valid && req.ready;

	cbm_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.kind        (kind),
		.address     (req.address),
		.write_data  (req.write_data),
		.bank_wr     (bank_wr),
		.irq_next    (irq_next),
		.mirror_next (mirror_next)
	);

	// pick the bank table entry a translate needs
	assign rd_idx = (kind == REQ_PPU) ? CHR_BASE + {1'b0, req.address[12:10]}
		: {2'b00, req.address[14:13]};

	cbm_bank_ram u_bank_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (bank_wr),
		.rd_en   (accept),
		.rd_idx  (rd_idx),
		.rd_bank (rd_bank)
	);

	// read stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_move) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind;
			addr_s1   <= req.address;
			irq_s1    <= irq_next;
			mirror_s1 <= mirror_next;
		end
	end

	// form the mapped address from the bank read
	always_comb begin
		item_s1.irq_line       = irq_s1;
		item_s1.mirror_mode    = mirror_s1;
		item_s1.target         = TGT_NONE;
		item_s1.mapped_address = '0;
		case (kind_s1)
			REQ_CPU: begin
				if (addr_s1 >= CPU_PRG_BASE) begin
					item_s1.target         = TGT_PRG;
					item_s1.mapped_address = {(addr_s1[14:13] == 2'b11) ? FIXED_BANK
						: rd_bank, addr_s1[12:0]};
				end else if (addr_s1 >= CPU_WRAM_BASE) begin
					item_s1.target         = TGT_WRAM;
					item_s1.mapped_address = {8'h00, addr_s1[12:0]};
				end
			end
			REQ_PPU: begin
				if (!addr_s1[13]) begin
					item_s1.target         = TGT_CHR;
					item_s1.mapped_address = {3'b000, rd_bank, addr_s1[9:0]};
				end
			end
			default: ;
		endcase
	end

	cbm_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (s1_move),
		.push_item  (item_s1),
		.full       (fifo_full),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop_ready  (rsp.ready)
	);

	assign rsp.valid          = head_valid;
	assign rsp.irq_line       = head_item.irq_line;
	assign rsp.target         = head_item.target;
	assign rsp.mapped_address = head_item.mapped_address;
	assign rsp.mirror_mode    = head_item.mirror_mode;

endmodule
